// File: src/rau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned OperandWidthDefault = 32;
    localparam int unsigned ProdWidth = 64;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_DIV = 2'd2,
        FUNC_RSV = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // front phases
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL0,
        FS_MUL1,
        FS_MUL2,
        FS_SUM,
        FS_PUSH
    } t_front_state;

    // back phases
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GCD,
        BS_DIVN,
        BS_DIVD,
        BS_DONE
    } t_back_state;

    // classified beat handed from front to back
    typedef struct packed {
        logic                  neg;
        logic [ProdWidth-1:0]  nmag;
        logic [ProdWidth-1:0]  dmag;
        t_status               status;
    } t_job;

endpackage

`default_nettype wire

// File: src/rational_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, multiply or divide two signed fractions, reduce by the gcd
// ----------------------------------------------------------------------------
// usage
//   input beat: start with i_func and four operand fields, taken at an
//   edge where busy is low
//   result beat: o_done high for one cycle with o_res_num, o_res_den and
//   o_status; the receiver cannot stall, so results are never held back
//   front: busy from each accept while it forms three products on one
//   32x32 multiplier, then sign fix-up and error classification, until
//   the beat enters the two-entry queue, so it takes one beat at a time
//   back: gcd as repeated 64-bit remainders on one bit-serial divider,
//   then two exact divisions on the same divider
//   error and zero items skip the gcd and the divisions
//   the front takes the next item while the back still reduces the last
//   reset clears both controllers and empties the queue, no clearing pass
//   status: 0 ok, 1 zero denominator, 2 divide by zero, 3 overflow
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_func,
    input  wire logic signed [31:0]  i_a_num,
    input  wire logic signed [31:0]  i_a_den,
    input  wire logic signed [31:0]  i_b_num,
    input  wire logic signed [31:0]  i_b_den,
    output logic                     o_done,
    output logic signed [31:0]       o_res_num,
    output logic [30:0]              o_res_den,
    output logic [1:0]               o_status
);
    import rau_pkg::*;

    logic push, full, pop, empty;
    t_job front_job, queue_job;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
        .i_func, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_push(push), .o_job(front_job), .i_full(full)
    );

    rau_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(front_job), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(queue_job)
    );

    rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(queue_job), .o_pop(pop),
        .o_done, .o_res_num, .o_res_den, .o_status
    );

    // error results are always zero over one
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_res_num == '0 && o_res_den == 31'd1)
        else $error("error result not zero over one");

    // denominator of a result is never zero
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res_den != '0)
        else $error("zero result denominator");

    // queue never pushed when full nor popped when empty
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue misuse");

endmodule

`default_nettype wire

// File: src/rau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_front
// converts operands to sign-magnitude, forms cross products on one shared
// multiplier in turn and classifies errors
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [1:0]               i_func,
    input  wire logic [31:0]              i_a_num,
    input  wire logic [31:0]              i_a_den,
    input  wire logic [31:0]              i_b_num,
    input  wire logic [31:0]              i_b_den,
    output logic                          o_push,
    output rau_pkg::t_job                 o_job,
    input  wire logic                     i_full
);
    import rau_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH;

    t_front_state r_state, n_state;
    t_func        r_func;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;   // magnitudes
    logic         r_san, r_sad, r_sbn, r_sbd;
    logic [ProdWidth-1:0] r_p0, r_p1, r_p2;
    t_job         r_job, n_job;

    logic [W-1:0] mul_x, mul_y;
    logic [ProdWidth-1:0] mul_p;
    logic         accept;

    function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        mag_of = v[W-1] ? (~v + 1'b1) : v;  // most negative wraps to 2^(W-1)
    endfunction

    assign accept = i_start && (r_state == FS_IDLE);
    assign o_busy = (r_state != FS_IDLE);
    assign o_push = (r_state == FS_PUSH) && !i_full;
    assign o_job  = r_job;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (accept) n_state = FS_MUL0;
            FS_MUL0: n_state = FS_MUL1;
            FS_MUL1: n_state = FS_MUL2;
            FS_MUL2: n_state = FS_SUM;
            FS_SUM:  n_state = FS_PUSH;
            FS_PUSH: if (!i_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_x = r_ad;
        mul_y = r_bd;
        case (r_state)
            FS_MUL0: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
            FS_MUL1: begin
                mul_x = r_an;
                mul_y = (r_func == FUNC_MUL) ? r_bn : r_bd;
            end
            FS_MUL2: begin
                mul_x = (r_func == FUNC_DIV) ? r_ad : r_bn;
                mul_y = (r_func == FUNC_DIV) ? r_bn : r_ad;
            end
            default: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
        endcase
    end

    assign mul_p = ProdWidth'(mul_x) * ProdWidth'(mul_y);

    // sign fix-up and error classification
    always_comb begin
        n_job = r_job;
        if (r_state == FS_SUM) begin
            n_job.status = ST_OK;
            n_job.dmag   = r_p0;
            n_job.nmag   = r_p1;
            n_job.neg    = 1'b0;
            if (r_ad == '0 || r_bd == '0) begin
                n_job.status = ST_ZERO_DEN;
            end else if (r_func == FUNC_MUL) begin
                n_job.neg  = r_san ^ r_sbn ^ r_sad ^ r_sbd;
            end else if (r_func == FUNC_DIV) begin
                if (r_bn == '0) begin
                    n_job.status = ST_DIV_ZERO;
                end else begin
                    n_job.dmag = r_p2;
                    n_job.neg  = r_san ^ r_sbd ^ r_sad ^ r_sbn;
                end
            end else begin
                // add: an*bd +/- bn*ad over ad*bd
                if ((r_san ^ r_sbd) == (r_sbn ^ r_sad)) begin
                    n_job.nmag = r_p1 + r_p2;
                    n_job.neg  = r_san ^ r_sbd ^ r_sad ^ r_sbd;
                end else if (r_p1 >= r_p2) begin
                    n_job.nmag = r_p1 - r_p2;
                    n_job.neg  = r_san ^ r_sbd ^ r_sad ^ r_sbd;
                end else begin
                    n_job.nmag = r_p2 - r_p1;
                    n_job.neg  = r_sbn ^ r_sad ^ r_sad ^ r_sbd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_an   <= mag_of(i_a_num);
            r_ad   <= mag_of(i_a_den);
            r_bn   <= mag_of(i_b_num);
            r_bd   <= mag_of(i_b_den);
            r_san  <= i_a_num[W-1];
            r_sad  <= i_a_den[W-1];
            r_sbn  <= i_b_num[W-1];
            r_sbd  <= i_b_den[W-1];
        end
        case (r_state)
            FS_MUL0: r_p0 <= mul_p;
            FS_MUL1: r_p1 <= mul_p;
            FS_MUL2: r_p2 <= mul_p;
            default: ;
        endcase
        r_job <= n_job;
    end

endmodule

`default_nettype wire

// File: src/rau_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module rau_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rau_pkg::t_job      i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output rau_pkg::t_job      o_job
);
    import rau_pkg::*;

    localparam int unsigned AW = $clog2(QueueDepth);

    t_job          r_mem [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

`default_nettype wire

// File: src/rau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_back
// euclidean gcd and the two exact divisions by it on one restoring
// divider, one quotient bit per cycle, then range check and result strobe
// ----------------------------------------------------------------------------
module rau_back #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  rau_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_done,
    output logic signed [31:0]        o_res_num,
    output logic [30:0]               o_res_den,
    output logic [1:0]                o_status
);
    import rau_pkg::*;

    localparam int unsigned PW = ProdWidth;
    localparam int unsigned CW = $clog2(PW);
    localparam logic [PW-1:0] Limit = (PW'(1) << (OPERAND_WIDTH - 1)) - PW'(1);

    t_back_state r_state, n_state;
    t_job          r_job, n_job;
    logic [PW-1:0] r_dvd, n_dvd;      // dividend, msb first
    logic [PW-1:0] r_dvs, n_dvs;      // divisor, holds the gcd at the end
    logic [PW-1:0] r_rem, n_rem;
    logic [PW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_qn, n_qn;        // reduced numerator magnitude
    logic [PW-1:0] r_qd, n_qd;        // reduced denominator
    logic          r_done;
    logic signed [31:0] r_num, n_num;
    logic [30:0]   r_den, n_den;
    logic [1:0]    r_st, n_st;

    logic [PW:0]   trial;
    logic [PW-1:0] rem_sh, rem_fin, quo_fin;
    logic          div_last, job_trivial;

    assign rem_sh      = {r_rem[PW-2:0], r_dvd[PW-1]};
    assign trial       = {r_rem, r_dvd[PW-1]} - {1'b0, r_dvs};
    assign rem_fin     = trial[PW] ? rem_sh : trial[PW-1:0];
    assign quo_fin     = {r_quo[PW-2:0], ~trial[PW]};
    assign div_last    = (r_cnt == CW'(PW-1));
    assign job_trivial = (i_job.status != ST_OK) || (i_job.nmag == '0);

    assign o_pop     = (r_state == BS_IDLE) && !i_empty;
    assign o_done    = r_done;
    assign o_res_num = r_num;
    assign o_res_den = r_den;
    assign o_status  = r_st;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (!i_empty) n_state = job_trivial ? BS_DONE : BS_GCD;
            BS_GCD:  if (div_last && rem_fin == '0) n_state = BS_DIVN;
            BS_DIVN: if (div_last) n_state = BS_DIVD;
            BS_DIVD: if (div_last) n_state = BS_DONE;
            BS_DONE: n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        n_job = r_job;
        n_dvd = r_dvd;
        n_dvs = r_dvs;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_qn  = r_qn;
        n_qd  = r_qd;
        n_num = r_num;
        n_den = r_den;
        n_st  = r_st;
        // one restoring step per cycle in every dividing phase
        if (r_state == BS_GCD || r_state == BS_DIVN || r_state == BS_DIVD) begin
            n_dvd = {r_dvd[PW-2:0], 1'b0};
            n_rem = rem_fin;
            n_quo = quo_fin;
            n_cnt = r_cnt + 1'b1;
        end
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    n_job = i_job;
                    n_dvd = i_job.nmag;
                    n_dvs = i_job.dmag;
                    n_rem = '0;
                    n_quo = '0;
                    n_cnt = '0;
                end
            end
            BS_GCD: begin
                // old divisor over nonzero remainder next, else gcd found
                if (div_last) begin
                    n_rem = '0;
                    n_quo = '0;
                    if (rem_fin == '0) begin
                        n_dvd = r_job.nmag;
                    end else begin
                        n_dvd = r_dvs;
                        n_dvs = rem_fin;
                    end
                end
            end
            BS_DIVN: begin
                if (div_last) begin
                    n_qn  = quo_fin;
                    n_dvd = r_job.dmag;
                    n_rem = '0;
                    n_quo = '0;
                end
            end
            BS_DIVD: if (div_last) n_qd = quo_fin;
            BS_DONE: begin
                n_num = '0;
                n_den = 31'd1;
                n_st  = r_job.status;
                if (r_job.status == ST_OK && r_job.nmag != '0) begin
                    if (r_qn > Limit || r_qd > Limit) begin
                        n_st = ST_OVERFLOW;
                    end else begin
                        n_num = r_job.neg ? -r_qn[31:0] : r_qn[31:0];
                        n_den = r_qd[30:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == BS_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_qn  <= n_qn;
        r_qd  <= n_qd;
        r_num <= n_num;
        r_den <= n_den;
        r_st  <= n_st;
    end

endmodule

`default_nettype wire
